FILE: hw/rtl/software_timer_bank_macros.svh
// Assertion macros shared by the timer bank RTL.
`ifndef SOFTWARE_TIMER_BANK_MACROS_SVH
`define SOFTWARE_TIMER_BANK_MACROS_SVH

`ifndef SYNTH
// Checks that the antecedent implies the consequent in the same cycle.
`define STB_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");
// Checks that the antecedent implies the consequent in the next cycle.
`define STB_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define STB_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define STB_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

FILE: hw/rtl/stb_pkg.sv
// Types, constants and helper functions of the software timer bank.
`default_nettype none
package stb_pkg;

   localparam int MAX_TIMERS = 8;
   localparam int ID_CNT     = 8;
   localparam int NUM_CELLS  = (MAX_TIMERS < ID_CNT) ? MAX_TIMERS : ID_CNT;
   localparam int ID_W       = 3;
   localparam int CNT_W      = 32;
   localparam int MODE_W     = 3;
   localparam int STAT_W     = 2;

   localparam logic [MODE_W-1:0] MODE_TICK   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_CREATE = 3'd1;
   localparam logic [MODE_W-1:0] MODE_DELETE = 3'd2;
   localparam logic [MODE_W-1:0] MODE_START  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_STOP   = 3'd4;
   localparam logic [MODE_W-1:0] MODE_RESET  = 3'd5;
   localparam logic [MODE_W-1:0] MODE_SET_AR = 3'd6;
   localparam logic [MODE_W-1:0] MODE_SET_RL = 3'd7;

   localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_NO_ID = 2'd2;

   localparam logic EV_DONE   = 1'b0;
   localparam logic EV_EXPIRY = 1'b1;

   // One list slot: the timer that sits at this position of the list.
   typedef struct packed {
      logic             occ;
      logic             en;
      logic             rep;
      logic [ID_W-1:0]  id;
      logic [CNT_W-1:0] period;
      logic [CNT_W-1:0] count;
   } cell_state_type;

   // Operation broadcast to every cell in the accepting cycle.
   typedef struct packed {
      logic              go;
      logic [MODE_W-1:0] mode;
      logic [ID_W-1:0]   timer_id;
      logic [CNT_W-1:0]  reload;
      logic              auto_reload;
      logic              start_now;
      logic [ID_W-1:0]   new_id;
   } cmd_type;

   // Position of the lowest set bit; zero when no bit is set.
   function automatic logic [ID_W-1:0] lowest_one(input logic [ID_CNT-1:0] vec);
      logic [ID_W-1:0] pos;
      pos = '0;
      for (int i = ID_CNT - 1; i >= 0; i--) begin
         if (vec[i]) begin
            pos = ID_W'(i);
         end
      end
      return pos;
   endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/software_timer_bank.sv
// Top level of the software timer bank: cell chain, result sequencer and stream ports.
`default_nettype none
`include "software_timer_bank_macros.svh"
// The bank keeps up to eight down-counting timers in an ordered list, one list
// position per cell of a chain. Each request transaction carries one operation
// (tick, create, delete, start, stop, reset, set auto-reload, set reload value)
// and is applied to every cell in the cycle it is accepted; a delete makes every
// cell behind the deleted entry take over its right neighbor in that same cycle.
// A tick decrements all enabled nonzero timers at once and marks those that expire; the
// result sequencer then sends one expiry transaction per marked timer, in list
// order, and closes every request with one completion transaction that has tlast
// set. The sequencer loads one result a cycle into the response register whenever
// that register is empty or tready is high. A new request is taken once the
// completion has been loaded, even while that completion still waits for tready.
// Timer ids are assigned at create time as the lowest free id. Reading a timer
// that was never created is not possible, as every operation on a free id is
// answered with status "id not in use" and changes nothing.
module software_timer_bank (
   input  wire logic        clock,
   input  wire logic        reset,
   // req_tdata from bit 0: mode[2:0], timer_id[5:3], reload_value[37:6],
   // auto_reload[38], start_now[39]
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [39:0] req_tdata,
   // rsp_tdata from bit 0: event_timer[2:0], status[4:3], elapsed_ticks[36:5],
   // zero fill[39:37]
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [39:0] rsp_tdata,
   // rsp_tuser: event_kind[0]
   output      logic        rsp_tuser,
   output      logic        rsp_tlast
);
   import stb_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EMIT = 1'b1;

   logic              state_ff, state_in;
   logic [ID_CNT-1:0] pend_ff, pend_in;
   logic [CNT_W-1:0]  ticks_ff, ticks_in;
   logic [ID_W-1:0]   done_timer_ff, done_timer_in;
   logic [STAT_W-1:0] done_stat_ff, done_stat_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [39:0]       rsp_data_ff, rsp_data_in;
   logic              rsp_user_ff, rsp_user_in;
   logic              rsp_last_ff, rsp_last_in;

   cmd_type           cmd;
   cell_state_type    chain_st [0:ID_CNT];
   logic              del_chain [0:ID_CNT];
   logic [ID_CNT-1:0] expire_vec;
   logic [ID_CNT-1:0] match_vec;
   logic [ID_CNT-1:0] occ_vec;
   logic [ID_CNT-1:0] in_use;
   logic              accept;
   logic              out_free;
   logic              full;
   logic [ID_W-1:0]   emit_pos;

   assign accept   = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);

   // Occupied cells always form a prefix of the chain, so the last one tells full.
   assign full = occ_vec[NUM_CELLS-1];

   always_comb begin
      in_use = '0;
      for (int i = 0; i < ID_CNT; i++) begin
         if (chain_st[i].occ) begin
            in_use[chain_st[i].id] = 1'b1;
         end
      end
   end

   always_comb begin
      cmd.go          = accept;
      cmd.mode        = req_tdata[2:0];
      cmd.timer_id    = req_tdata[5:3];
      cmd.reload      = req_tdata[37:6];
      cmd.auto_reload = req_tdata[38];
      cmd.start_now   = req_tdata[39];
      cmd.new_id      = lowest_one(~in_use);
   end

   assign del_chain[0]      = (cmd.mode != MODE_DELETE);
   assign chain_st[ID_CNT]  = '0;

   for (genvar i = 0; i < ID_CNT; i++) begin : g_cell
      if (i < NUM_CELLS) begin : g_live
         logic prev_occ;
         if (i == 0) begin : g_head
            assign prev_occ = 1'b1;
         end else begin : g_body
            assign prev_occ = chain_st[i-1].occ;
         end
         stb_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .cmd      (cmd),
            .prev_occ (prev_occ),
            .del_in   (del_chain[i] && (cmd.mode == MODE_DELETE)),
            .right_in (chain_st[i+1]),
            .del_out  (del_chain[i+1]),
            .st_out   (chain_st[i]),
            .expire   (expire_vec[i]),
            .match    (match_vec[i])
         );
      end else begin : g_none
         assign chain_st[i]    = '0;
         assign del_chain[i+1] = 1'b0;
         assign expire_vec[i]  = 1'b0;
         assign match_vec[i]   = 1'b0;
      end
      assign occ_vec[i] = chain_st[i].occ;
   end

   assign emit_pos = lowest_one(pend_ff);

   always_comb begin
      state_in      = state_ff;
      pend_in       = pend_ff;
      ticks_in      = ticks_ff;
      done_timer_in = done_timer_ff;
      done_stat_in  = done_stat_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_user_in   = rsp_user_ff;
      rsp_last_in   = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EMIT;
               case (cmd.mode)
                  MODE_TICK: begin
                     ticks_in      = ticks_ff + CNT_W'(1);
                     pend_in       = expire_vec;
                     done_timer_in = '0;
                     done_stat_in  = STAT_OK;
                  end
                  MODE_CREATE: begin
                     done_timer_in = full ? '0 : cmd.new_id;
                     done_stat_in  = full ? STAT_FULL : STAT_OK;
                  end
                  default: begin
                     done_timer_in = cmd.timer_id;
                     done_stat_in  = (match_vec != '0) ? STAT_OK : STAT_NO_ID;
                  end
               endcase
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (pend_ff != '0) begin
                  rsp_data_in = {3'b000, ticks_ff, STAT_OK, chain_st[{1'b0, emit_pos}].id};
                  rsp_user_in = EV_EXPIRY;
                  rsp_last_in = 1'b0;
                  pend_in     = pend_ff & (pend_ff - ID_CNT'(1));
               end else begin
                  rsp_data_in = {3'b000, ticks_ff, done_stat_ff, done_timer_ff};
                  rsp_user_in = EV_DONE;
                  rsp_last_in = 1'b1;
                  state_in    = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= '0;
         ticks_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         ticks_ff     <= ticks_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      done_timer_ff <= done_timer_in;
      done_stat_ff  <= done_stat_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_user_ff   <= rsp_user_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   // An accepted request always moves the sequencer out of idle.
   `STB_ASSERT_NEXT(a_accept_emits, clock, reset, accept, state_ff == ST_EMIT)
   // Expiry marks only live while results are being sent.
   `STB_ASSERT_SAME(a_pend_idle, clock, reset, state_ff == ST_IDLE, pend_ff == '0)
   // An expiry transaction never closes a request.
   `STB_ASSERT_SAME(a_expiry_not_last, clock, reset, rsp_valid_ff && rsp_user_ff, !rsp_last_ff)
   // Occupied cells stay packed at the head of the chain.
   `STB_ASSERT_SAME(a_occ_prefix, clock, reset, 1'b1, (occ_vec & (occ_vec + ID_CNT'(1))) == '0)

endmodule
`default_nettype wire

FILE: hw/rtl/stb_cell.sv
// One list slot of the timer bank: holds a timer and shifts toward the head on delete.
`default_nettype none
module stb_cell (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire stb_pkg::cmd_type       cmd,
   input  wire logic                   prev_occ,
   input  wire logic                   del_in,
   input  wire stb_pkg::cell_state_type right_in,
   output      logic                   del_out,
   output      stb_pkg::cell_state_type st_out,
   output      logic                   expire,
   output      logic                   match
);
   import stb_pkg::*;

   cell_state_type st_ff;
   cell_state_type st_in;
   logic           append;

   assign match   = st_ff.occ && (st_ff.id == cmd.timer_id);
   assign append  = !st_ff.occ && prev_occ;
   assign del_out = del_in || match;
   assign st_out  = st_ff;

   always_comb begin
      st_in  = st_ff;
      expire = 1'b0;
      if (cmd.go) begin
         case (cmd.mode)
            MODE_TICK: begin
               if (st_ff.occ && st_ff.en && (st_ff.count != '0)) begin
                  if (st_ff.count == CNT_W'(1)) begin
                     expire      = 1'b1;
                     st_in.count = st_ff.period;
                     st_in.en    = st_ff.rep;
                  end else begin
                     st_in.count = st_ff.count - CNT_W'(1);
                  end
               end
            end
            MODE_CREATE: begin
               if (append) begin
                  st_in.occ    = 1'b1;
                  st_in.id     = cmd.new_id;
                  st_in.period = cmd.reload;
                  st_in.count  = cmd.reload;
                  st_in.en     = cmd.start_now;
                  st_in.rep    = cmd.auto_reload;
               end
            end
            MODE_DELETE: begin
               // Every slot from the deleted one onward takes its right neighbor.
               if (del_in || match) begin
                  st_in = right_in;
               end
            end
            MODE_START:  if (match) st_in.en = 1'b1;
            MODE_STOP:   if (match) st_in.en = 1'b0;
            MODE_RESET:  if (match) st_in.count = st_ff.period;
            MODE_SET_AR: if (match) st_in.rep = cmd.auto_reload;
            MODE_SET_RL: if (match) st_in.period = cmd.reload;
            default: st_in = st_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff.occ <= 1'b0;
         st_ff.en  <= 1'b0;
         st_ff.rep <= 1'b0;
      end else begin
         st_ff <= st_in;
      end
   end

endmodule
`default_nettype wire
